FILE: hw/rtl/rda_pkg.sv
// Shared constants and the query record for the rank distance accumulator.
`default_nettype none

package rda_pkg;

    // Capacity of one vector and the derived widths
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Field widths
    localparam int RANK_W    = 7;
    localparam int SHARE_W   = 2 * RANK_W;
    localparam int VEC_W     = 17;
    localparam int TOT_W     = 27;
    localparam int METRIC_W  = 2;

    localparam logic [VEC_W-1:0] VEC_MAX = {VEC_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // Metric select codes (the unused code behaves as footrule)
    localparam logic [METRIC_W-1:0] METRIC_FOOTRULE = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_KENDALL  = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_SPEARMAN = 2'd2;

    // One element travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic [RANK_W-1:0]  rank_a;
        logic [RANK_W-1:0]  rank_b;
        logic [IDX_W-1:0]   idx;       // position of the element in its vector
        logic               ignored;   // beyond capacity: no store, no share
        logic               kendall;   // count discordant pairs in the cells
        logic               last_vec;
        logic               last_set;
        logic [SHARE_W-1:0] share;     // distance share, grows in Kendall mode
    } t_query;

endpackage

`default_nettype wire

FILE: hw/rtl/rank_distance_accumulator.sv
// Rank distance accumulator: the front stage, the cell chain and the tail.
//
// Usage: each input item is one rank pair (rank_a of the assessor, rank_b of
// the reference) with last_in_vector / last_in_set marks. Input and output
// channels use valid/stall; an item moves on a clock edge with valid high
// and stall low. The metric register (0 footrule, 1 Kendall, 2 Spearman,
// 3 as footrule) is written through the cfg valid/ready port, which is
// always ready; write it only while the block is idle.
// Each element enters a chain of MAX_ITEMS cells and moves one cell per
// cycle unless the chain is held; cell j stores element j of the vector
// and in Kendall mode counts discordant pairs for every later element
// passing it. Throughput is one item per cycle unless the chain is held.
// The last vector element passes the front, chain and result registers.
// Elements beyond MAX_ITEMS of a vector are dropped and reported in status.
// When the output register holds a result and the receiver stalls, the chain
// keeps moving until the next result reaches its tail; then the whole chain
// and the input hold (input stall goes high) until the result is taken.
// Synchronous active-low reset empties the chain, clears the sums and the
// result valid flag and sets the metric to footrule; no clearing pass.
`default_nettype none

module rank_distance_accumulator import rda_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [METRIC_W-1:0] i_cfg_data,
    // Input items
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [RANK_W-1:0]   i_rank_a,
    input  wire logic [RANK_W-1:0]   i_rank_b,
    input  wire logic                i_last_in_vector,
    input  wire logic                i_last_in_set,
    // Result items
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [VEC_W-1:0]         o_vector_distance,
    output logic [TOT_W-1:0]         o_set_total,
    output logic                     o_set_done,
    output logic                     o_status
);

    logic [METRIC_W-1:0] r_metric;
    logic [CNT_W-1:0]    r_count;
    t_query              r_front;
    t_query              n_front;
    logic                w_advance;
    logic                w_accept;
    logic                w_full;
    logic [RANK_W-1:0]   w_diff;
    logic [SHARE_W-1:0]  w_square;
    t_query              w_chain [MAX_ITEMS+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !w_advance;
    assign w_accept    = i_in_valid && w_advance;

    // Metric register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= METRIC_FOOTRULE;
        end else if (i_cfg_valid) begin
            r_metric <= i_cfg_data;
        end
    end

    // Element position within the vector, saturating at capacity
    assign w_full = (r_count == CNT_W'(MAX_ITEMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            if (i_last_in_vector) begin
                r_count <= '0;
            end else if (!w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Front stage: absolute difference and its square
    assign w_diff   = (i_rank_a > i_rank_b) ? (i_rank_a - i_rank_b) : (i_rank_b - i_rank_a);
    assign w_square = SHARE_W'(w_diff) * SHARE_W'(w_diff);

    always_comb begin
        n_front.valid    = i_in_valid;
        n_front.rank_a   = i_rank_a;
        n_front.rank_b   = i_rank_b;
        n_front.idx      = r_count[IDX_W-1:0];
        n_front.ignored  = w_full;
        n_front.kendall  = (r_metric == METRIC_KENDALL);
        n_front.last_vec = i_last_in_vector;
        n_front.last_set = i_last_in_set;
        unique case (r_metric)
            METRIC_KENDALL:  n_front.share = '0;
            METRIC_SPEARMAN: n_front.share = w_square;
            default:         n_front.share = SHARE_W'(w_diff);
        endcase
        if (w_full) begin
            n_front.share = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
        end else if (w_advance) begin
            r_front <= n_front;
        end
    end

    // Cell chain, one stored pair per cell
    assign w_chain[0] = r_front;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        rda_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_index   (IDX_W'(g)),
            .i_query   (w_chain[g]),
            .o_query   (w_chain[g+1])
        );
    end

    // Tail: sums and result register
    rda_accum u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_query           (w_chain[MAX_ITEMS]),
        .i_out_stall       (i_out_stall),
        .o_advance         (w_advance),
        .o_out_valid       (o_out_valid),
        .o_vector_distance (o_vector_distance),
        .o_set_total       (o_set_total),
        .o_set_done        (o_set_done),
        .o_status          (o_status)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rda_cell.sv
// One chain cell: holds one stored rank pair and checks passing elements against it.
`default_nettype none

module rda_cell import rda_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_query           i_query,
    output t_query                o_query
);

    logic [RANK_W-1:0] r_rank_a;
    logic [RANK_W-1:0] r_rank_b;
    t_query            r_query;
    t_query            n_query;
    logic              w_store;
    logic              w_check;
    logic              w_discord;

    // An element writes the cell at its own position; later ones compare in Kendall mode
    assign w_store = i_query.valid && !i_query.ignored && (i_query.idx == i_index);
    assign w_check = i_query.valid && !i_query.ignored && i_query.kendall
                     && (i_query.idx > i_index);

    // Discordant pair, ties in either ranking do not count
    assign w_discord = ((r_rank_a > i_query.rank_a) && (r_rank_b < i_query.rank_b)) ||
                       ((r_rank_a < i_query.rank_a) && (r_rank_b > i_query.rank_b));

    always_comb begin
        n_query = i_query;
        if (w_check && w_discord) begin
            n_query.share = i_query.share + SHARE_W'(1);
        end
    end

    // Stored pair, written once per vector
    always_ff @(posedge i_clk) begin
        if (i_advance && w_store) begin
            r_rank_a <= i_query.rank_a;
            r_rank_b <= i_query.rank_b;
        end
    end

    // Hand the element on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (i_advance) begin
            r_query <= n_query;
        end
    end

    assign o_query = r_query;

endmodule

`default_nettype wire

FILE: hw/rtl/rda_accum.sv
// Chain tail: per-vector sum, running total, result register and chain hold.
`default_nettype none

module rda_accum import rda_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_query            i_query,
    input  wire logic              i_out_stall,
    output logic                   o_advance,
    output logic                   o_out_valid,
    output logic [VEC_W-1:0]       o_vector_distance,
    output logic [TOT_W-1:0]       o_set_total,
    output logic                   o_set_done,
    output logic                   o_status
);

    logic [VEC_W-1:0] r_partial;
    logic [TOT_W-1:0] r_total;
    logic             r_ovf;
    logic             r_out_valid;
    logic [VEC_W-1:0] r_vec;
    logic [TOT_W-1:0] r_tot;
    logic             r_done;
    logic             r_status;

    logic [VEC_W-1:0] n_partial;
    logic [TOT_W-1:0] n_total;
    logic             n_ovf;
    logic [VEC_W:0]   w_psum;
    logic [TOT_W:0]   w_tsum;
    logic             w_take;
    logic             w_result;

    // Hold the whole chain only when a result meets a full, stalled output
    assign o_advance = !(i_query.valid && i_query.last_vec && r_out_valid && i_out_stall);
    assign w_take    = o_advance && i_query.valid;
    assign w_result  = w_take && i_query.last_vec;

    // Saturating adds: element share into the vector, vector into the total
    assign w_psum    = {1'b0, r_partial} + (VEC_W + 1)'(i_query.share);
    assign n_partial = w_psum[VEC_W] ? VEC_MAX : w_psum[VEC_W-1:0];
    assign w_tsum    = {1'b0, r_total} + (TOT_W + 1)'(n_partial);
    assign n_total   = w_tsum[TOT_W] ? TOT_MAX : w_tsum[TOT_W-1:0];
    assign n_ovf     = r_ovf || i_query.ignored;

    // Vector and set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_total   <= '0;
            r_ovf     <= 1'b0;
        end else if (w_result) begin
            r_partial <= '0;
            r_ovf     <= 1'b0;
            r_total   <= i_query.last_set ? '0 : n_total;
        end else if (w_take) begin
            r_partial <= n_partial;
            r_ovf     <= n_ovf;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_vec    <= n_partial;
            r_tot    <= n_total;
            r_done   <= i_query.last_set;
            r_status <= n_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_vector_distance = r_vec;
    assign o_set_total       = r_tot;
    assign o_set_done        = r_done;
    assign o_status          = r_status;

`ifndef ASSERT_OFF
    // A closed set leaves a zero total behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_result && i_query.last_set) |=> (r_total == '0))
        else $error("total not cleared after set end");

    // A closed vector leaves no partial sum or overflow mark
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result |=> ((r_partial == '0) && !r_ovf))
        else $error("vector state not cleared after vector end");

    // The total always includes the vector it reports
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_set_total >= TOT_W'(o_vector_distance)))
        else $error("total below vector distance");

    // A held chain leaves the vector sum untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_advance |=> $stable(r_partial))
        else $error("partial sum moved while chain held");
`endif

endmodule

`default_nettype wire
